>>> design/lprl_pkg.sv
`timescale 1ns / 1ps
// Shared types, status codes and helpers for the longest-prefix route lookup.
// No dependencies; used by lprl_cell and longest_prefix_route_lookup_top.
package lprl_pkg;

    localparam int unsigned DEFAULT_ROUTE_SLOTS = 16;
    localparam int unsigned MAX_PREFIX = 32;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ROUTE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] ip_addr;
        logic [5:0]  prefix_len;
        logic [7:0]  next_hop;
        logic [15:0] route_metric;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  hop_result;
        logic [15:0] metric_result;
        logic [5:0]  match_len;
    } t_result;

    // Transaction as it walks down the cell chain. On a lookup, len, hop and
    // metric hold the best route found so far.
    typedef struct packed {
        logic        cmd;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [7:0]  hop;
        logic [15:0] metric;
        logic        full;
        logic        found;
    } t_token;

    function automatic logic [31:0] mask_of(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = 32'd0;
        end else if (len >= 6'(MAX_PREFIX)) begin
            m = 32'hFFFF_FFFF;
        end else begin
            m = 32'hFFFF_FFFF << (6'(MAX_PREFIX) - len);
        end
        return m;
    endfunction

endpackage

>>> design/lprl_cell.sv
`timescale 1ns / 1ps
// One route slot of the lookup chain: stores a route and updates the passing
// transaction. Depends on lprl_pkg.
module lprl_cell #(
    parameter int unsigned SLOT_W   = 4,
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  lprl_pkg::t_token    i_tok,
    input  logic [SLOT_W-1:0]   i_slot,
    output logic                o_vld,
    output lprl_pkg::t_token    o_tok,
    output logic [SLOT_W-1:0]   o_slot
);

    logic             r_valid;
    logic [31:0]      r_net;
    logic [5:0]       r_len;
    logic [7:0]       r_hop;
    logic [15:0]      r_metric;

    logic             r_vld;
    lprl_pkg::t_token r_tok;
    logic [SLOT_W-1:0] r_slot;

    logic             n_write;
    logic             n_take;
    logic             n_hit;
    lprl_pkg::t_token n_tok;

    always_comb begin
        n_write = i_vld && (i_tok.cmd == lprl_pkg::CMD_ADD) && !i_tok.full &&
                  (i_slot == SLOT_W'(CELL_IDX));
        n_hit   = r_valid && ((i_tok.addr & lprl_pkg::mask_of(r_len)) == r_net);
        // Strict compares keep the earliest slot on a full tie.
        n_take  = (i_tok.cmd == lprl_pkg::CMD_LOOKUP) && n_hit &&
                  (!i_tok.found || (r_len > i_tok.len) ||
                   ((r_len == i_tok.len) && (r_metric < i_tok.metric)));
        n_tok = i_tok;
        if (n_take) begin
            n_tok.found  = 1'b1;
            n_tok.len    = r_len;
            n_tok.hop    = r_hop;
            n_tok.metric = r_metric;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_vld <= i_vld;
            if (n_write) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_write) begin
            r_net    <= i_tok.addr;
            r_len    <= i_tok.len;
            r_hop    <= i_tok.hop;
            r_metric <= i_tok.metric;
        end
        r_tok  <= n_tok;
        r_slot <= i_slot;
    end

    assign o_vld  = r_vld;
    assign o_tok  = r_tok;
    assign o_slot = r_slot;

endmodule

>>> design/longest_prefix_route_lookup_top.sv
`timescale 1ns / 1ps
// Top level of the IPv4 longest-prefix route lookup: slot counter, entry
// formatting and a chain of lprl_cell slots. Depends on lprl_pkg, lprl_cell.
//
//  Channel   Signals                  Direction  Handshake
//  -------   -----------------------  ---------  ------------------------------
//  command   start, busy, i_item      in         taken when start && !busy
//  result    o_strobe, o_result       out        one-cycle strobe, no stall
//
// Each transaction passes through all ROUTE_SLOTS cells, one register each,
// and its result leaves the last cell. A new transaction can be taken every
// cycle; busy is always low. The cells see transactions in order, so a lookup
// always sees every route added before it. Synchronous reset clears the
// chain, all slot valid bits and the route count. The receiver cannot stall.
module longest_prefix_route_lookup_top #(
    parameter int unsigned ROUTE_SLOTS = lprl_pkg::DEFAULT_ROUTE_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lprl_pkg::t_item   i_item,
    output logic              o_strobe,
    output lprl_pkg::t_result o_result
);

    localparam int unsigned SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int unsigned CNT_W  = $clog2(ROUTE_SLOTS + 1);

    logic [CNT_W-1:0]  r_count;
    logic              n_full;
    logic [5:0]        n_len;
    lprl_pkg::t_token  n_tok;

    logic              chain_vld  [0:ROUTE_SLOTS];
    lprl_pkg::t_token  chain_tok  [0:ROUTE_SLOTS];
    logic [SLOT_W-1:0] chain_slot [0:ROUTE_SLOTS];

    lprl_pkg::t_token  last_tok;

    assign busy = 1'b0;

    always_comb begin
        n_full = (r_count == CNT_W'(ROUTE_SLOTS));
        n_len  = (i_item.prefix_len > 6'(lprl_pkg::MAX_PREFIX)) ?
                 6'(lprl_pkg::MAX_PREFIX) : i_item.prefix_len;
        n_tok.cmd    = i_item.cmd;
        n_tok.addr   = (i_item.cmd == lprl_pkg::CMD_ADD) ?
                       (i_item.ip_addr & lprl_pkg::mask_of(n_len)) : i_item.ip_addr;
        n_tok.len    = n_len;
        n_tok.hop    = i_item.next_hop;
        n_tok.metric = i_item.route_metric;
        n_tok.full   = n_full;
        n_tok.found  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (start && !busy && (i_item.cmd == lprl_pkg::CMD_ADD) && !n_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign chain_vld[0]  = start && !busy;
    assign chain_tok[0]  = n_tok;
    assign chain_slot[0] = r_count[SLOT_W-1:0];

    for (genvar g = 0; g < ROUTE_SLOTS; g++) begin : g_cell
        lprl_cell #(
            .SLOT_W   (SLOT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (chain_vld[g]),
            .i_tok   (chain_tok[g]),
            .i_slot  (chain_slot[g]),
            .o_vld   (chain_vld[g+1]),
            .o_tok   (chain_tok[g+1]),
            .o_slot  (chain_slot[g+1])
        );
    end

    assign last_tok = chain_tok[ROUTE_SLOTS];
    assign o_strobe = chain_vld[ROUTE_SLOTS];

    always_comb begin
        o_result = '0;
        if (last_tok.cmd == lprl_pkg::CMD_ADD) begin
            o_result.status = last_tok.full ? lprl_pkg::ST_FULL : lprl_pkg::ST_OK;
        end else if (last_tok.found) begin
            o_result.status        = lprl_pkg::ST_OK;
            o_result.hop_result    = last_tok.hop;
            o_result.metric_result = last_tok.metric;
            o_result.match_len     = last_tok.len;
        end else begin
            o_result.status = lprl_pkg::ST_NO_ROUTE;
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, ROUTE_SLOTS))
        else $error("result strobe without a matching earlier transaction");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ROUTE_SLOTS))
        else $error("route count exceeds the number of slots");

    a_full_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == lprl_pkg::ST_FULL)) |->
        (r_count == CNT_W'(ROUTE_SLOTS)))
        else $error("table full reported while slots remain");

    a_no_route_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == lprl_pkg::ST_NO_ROUTE)) |->
        ((o_result.hop_result == 8'd0) && (o_result.metric_result == 16'd0) &&
         (o_result.match_len == 6'd0)))
        else $error("no-route result carries route data");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.match_len <= 6'(lprl_pkg::MAX_PREFIX)))
        else $error("match length above 32");

endmodule

>>> dv/longest_prefix_route_lookup_top_test.sv
`timescale 1ns / 1ps
// Self-checking test of longest_prefix_route_lookup_top: route adds and lookups, each
// reply checked against a route table kept here. Depends on lprl_pkg and the design.
module longest_prefix_route_lookup_top_test;
    import lprl_pkg::*;

    localparam int unsigned ROUTE_SLOTS = DEFAULT_ROUTE_SLOTS;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct {
        t_item   item;
        bit      known;
        t_result known_reply;
    } t_dir_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;

    // Route table as the lookup should see it.
    bit          route_ok [ROUTE_SLOTS];
    logic [31:0] route_net [ROUTE_SLOTS];
    logic [5:0]  route_len [ROUTE_SLOTS];
    logic [7:0]  route_hop [ROUTE_SLOTS];
    logic [15:0] route_metric [ROUTE_SLOTS];
    int          route_count = 0;

    t_result  pending_route_replies[$];
    t_dir_row dir_rows[$];
    int       mismatch_count = 0;

    longest_prefix_route_lookup_top #(
        .ROUTE_SLOTS(ROUTE_SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        if (len == 6'd0) begin
            return 32'd0;
        end
        return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    // Updates the route table for an add and returns the reply the block owes.
    function automatic t_result apply_route_cmd(input t_item it);
        t_result     r;
        logic [5:0]  len;
        logic [31:0] m;
        bit          found;
        r = '0;
        found = 1'b0;
        if (it.cmd == CMD_ADD) begin
            if (route_count >= ROUTE_SLOTS) begin
                r.status = ST_FULL;
            end else begin
                len = (it.prefix_len > 6'd32) ? 6'd32 : it.prefix_len;
                route_ok[route_count] = 1'b1;
                route_net[route_count] = it.ip_addr & prefix_mask(len);
                route_len[route_count] = len;
                route_hop[route_count] = it.next_hop;
                route_metric[route_count] = it.route_metric;
                route_count++;
                r.status = ST_OK;
            end
        end else begin
            for (int k = 0; k < ROUTE_SLOTS; k++) begin
                if (route_ok[k]) begin
                    m = prefix_mask(route_len[k]);
                    // Strict comparisons keep the lowest slot on a full tie.
                    if ((it.ip_addr & m) == (route_net[k] & m) &&
                        (!found || route_len[k] > r.match_len ||
                         (route_len[k] == r.match_len &&
                          route_metric[k] < r.metric_result))) begin
                        found = 1'b1;
                        r.match_len = route_len[k];
                        r.metric_result = route_metric[k];
                        r.hop_result = route_hop[k];
                    end
                end
            end
            r.status = found ? ST_OK : ST_NO_ROUTE;
        end
        return r;
    endfunction

    task automatic push_row(input logic cmd, input logic [31:0] addr, input logic [5:0] len,
                            input logic [7:0] hop, input logic [15:0] metric, input bit known,
                            input logic [1:0] st, input logic [7:0] r_hop,
                            input logic [15:0] r_metric, input logic [5:0] r_len);
        t_dir_row row;
        row.item = '{cmd, addr, len, hop, metric};
        row.known = known;
        row.known_reply = '{st, r_hop, r_metric, r_len};
        dir_rows = {dir_rows, row};
    endtask

    // Holds the transaction until it is taken, with random idle cycles before it.
    task automatic send_route_cmd(input t_item it, input bit known, input t_result known_reply,
                                  input bit may_idle);
        logic [63:0] noise;
        t_result     model_reply;
        while (may_idle && $urandom_range(99) < 27) begin
            noise = {$urandom, $urandom};
            start <= 1'b0;
            i_item <= noise[62:0];
            @(posedge i_clk);
        end
        i_item <= it;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        model_reply = apply_route_cmd(it);
        pending_route_replies = {pending_route_replies, (known ? known_reply : model_reply)};
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_route_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: unexpected reply: status %0d hop %0d metric %0d len %0d",
                         $time, o_result.status, o_result.hop_result,
                         o_result.metric_result, o_result.match_len);
            end else begin
                want = pending_route_replies.pop_front();
                if (o_result.status !== want.status || o_result.hop_result !== want.hop_result ||
                    o_result.metric_result !== want.metric_result ||
                    o_result.match_len !== want.match_len) begin
                    mismatch_count++;
                    $display({"%0t ns: expected status %0d hop %0d metric %0d len %0d, ",
                              "got %0d %0d %0d %0d"},
                             $time, want.status, want.hop_result, want.metric_result,
                             want.match_len, o_result.status, o_result.hop_result,
                             o_result.metric_result, o_result.match_len);
                end
            end
        end
    end

    initial begin
        t_item   it;
        t_result none;
        int      slot;
        int      pick;
        int      drain_cycles;
        bit      may_idle;
        none = '0;
        start <= 1'b0;
        i_item <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_row(CMD_LOOKUP, 32'h0A00_0001, 6'd0, 8'd0, 16'd0, 1'b1, ST_NO_ROUTE, 8'd0, 16'd0, 6'd0);
        push_row(CMD_ADD, 32'hFFFF_FFFF, 6'd32, 8'd255, 16'hFFFF, 1'b1, ST_OK, 8'd0, 16'd0, 6'd0);
        push_row(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0, 16'd0, 1'b1, ST_OK, 8'd255, 16'hFFFF,
                 6'd32);
        // A prefix length above 32 is stored as 32.
        push_row(CMD_ADD, 32'h0A0B_0C0D, 6'd63, 8'd1, 16'd0, 1'b1, ST_OK, 8'd0, 16'd0, 6'd0);
        push_row(CMD_LOOKUP, 32'h0A0B_0C0D, 6'd0, 8'd0, 16'd0, 1'b1, ST_OK, 8'd1, 16'd0, 6'd32);
        push_row(CMD_ADD, 32'h0AFF_FFFF, 6'd8, 8'd2, 16'd10, 1'b1, ST_OK, 8'd0, 16'd0, 6'd0);
        push_row(CMD_ADD, 32'h0A00_0000, 6'd8, 8'd3, 16'd5, 1'b1, ST_OK, 8'd0, 16'd0, 6'd0);
        // Same route twice: the earlier slot must win.
        push_row(CMD_ADD, 32'h0A00_0000, 6'd8, 8'd4, 16'd5, 1'b1, ST_OK, 8'd0, 16'd0, 6'd0);
        push_row(CMD_LOOKUP, 32'h0A0B_0C0E, 6'd63, 8'd255, 16'hFFFF, 1'b0, ST_OK, 8'd0, 16'd0,
                 6'd0);
        push_row(CMD_ADD, 32'h0A0B_0000, 6'd16, 8'd5, 16'hFFFF, 1'b1, ST_OK, 8'd0, 16'd0, 6'd0);
        push_row(CMD_LOOKUP, 32'h0A0B_FFFF, 6'd0, 8'd0, 16'd0, 1'b0, ST_OK, 8'd0, 16'd0, 6'd0);
        push_row(CMD_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'd0, 16'd0, 1'b1, ST_NO_ROUTE, 8'd0, 16'd0,
                 6'd0);
        // A zero-length route drops its address bits and matches everything.
        push_row(CMD_ADD, 32'h1234_5678, 6'd0, 8'd7, 16'd100, 1'b1, ST_OK, 8'd0, 16'd0, 6'd0);
        push_row(CMD_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'd0, 16'd0, 1'b0, ST_OK, 8'd0, 16'd0, 6'd0);
        // Nine more routes around 10.0.0.0/8 fill the table, with frequent metric ties.
        repeat (9) begin
            push_row(CMD_ADD, {8'h0A, 24'($urandom)}, 6'($urandom_range(8, 32)),
                     8'($urandom), 16'($urandom_range(0, 3)), 1'b0, ST_OK, 8'd0, 16'd0, 6'd0);
        end
        push_row(CMD_ADD, 32'h0102_0304, 6'd24, 8'd9, 16'd1, 1'b1, ST_FULL, 8'd0, 16'd0, 6'd0);
        push_row(CMD_LOOKUP, 32'h0A0B_0C0D, 6'd0, 8'd0, 16'd0, 1'b0, ST_OK, 8'd0, 16'd0, 6'd0);

        foreach (dir_rows[n]) begin
            send_route_cmd(dir_rows[n].item, dir_rows[n].known, dir_rows[n].known_reply, 1'b1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            it.cmd = ($urandom_range(99) < 10) ? CMD_ADD : CMD_LOOKUP;
            it.prefix_len = 6'($urandom_range(0, 63));
            it.next_hop = 8'($urandom);
            it.route_metric = 16'($urandom);
            pick = $urandom_range(99);
            if (it.cmd == CMD_LOOKUP && pick < 55 && route_count > 0) begin
                // Land inside a stored route, sometimes one bit outside its prefix.
                slot = $urandom_range(route_count - 1);
                it.ip_addr = route_net[slot] | ($urandom & ~prefix_mask(route_len[slot]));
                if ($urandom_range(3) == 0 && route_len[slot] != 6'd0) begin
                    it.ip_addr[32 - $urandom_range(1, route_len[slot])] ^= 1'b1;
                end
            end else if (it.cmd == CMD_LOOKUP && pick < 80) begin
                it.ip_addr = {8'h0A, 24'($urandom)};
            end else begin
                it.ip_addr = $urandom;
            end
            may_idle = (n < 500 || n >= 750);
            send_route_cmd(it, 1'b0, none, may_idle);
        end
        start <= 1'b0;

        drain_cycles = 0;
        while (pending_route_replies.size() != 0 && drain_cycles < 4000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (2 * ROUTE_SLOTS + 4) @(posedge i_clk);
        if (pending_route_replies.size() != 0) begin
            $display("%0t ns: %0d replies never arrived", $time, pending_route_replies.size());
        end
        if (mismatch_count == 0 && pending_route_replies.size() == 0) begin
            $display("longest_prefix_route_lookup_top_test OK");
        end else begin
            $display("longest_prefix_route_lookup_top_test NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("longest_prefix_route_lookup_top_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
design/lprl_pkg.sv
design/lprl_cell.sv
design/longest_prefix_route_lookup_top.sv
dv/longest_prefix_route_lookup_top_test.sv
